// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers on clk_i and rst_ni, removable by NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// check outside reset
`define ASSERT_CHK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
// check at every edge, reset included
`define ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("reset assertion failed");
`else
`define ASSERT_CHK(lbl, prop)
`define ASSERT_RST(lbl, prop)
`endif
`endif

// ----- sv/pac_pkg.sv -----
// ----------------------------------------------------------------------------
// pac_pkg
// Shared types and constants of the packet ACL classifier.
// ----------------------------------------------------------------------------
package pac_pkg;

  localparam int unsigned PrefixEntriesDef = 64;
  localparam int unsigned PortEntriesDef   = 64;
  localparam int unsigned RuleBitsDef      = 8;

  localparam int unsigned IdxW      = 6;
  localparam int unsigned GroupSize = 8;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  typedef enum logic [1:0] {
    OP_FILTER       = 2'd0,
    OP_WRITE_PREFIX = 2'd1,
    OP_WRITE_PORT   = 2'd2,
    OP_CLEAR_PREFIX = 2'd3
  } pac_op_e;

  typedef struct packed {
    logic            prefix_we;
    logic            prefix_clr;
    logic            port_we;
    logic [IdxW-1:0] index;
    logic [31:0]     network;
    logic [31:0]     mask;
    logic [15:0]     port;
    logic [1:0]      protocols;
    logic [7:0]      rule;
  } pac_wr_t;

endpackage

// ----- sv/pac_prefix_tbl.sv -----
// ----------------------------------------------------------------------------
// pac_prefix_tbl
// Prefix table with parallel compare of two addresses and a two-stage
// registered first-hit reduction.
// ----------------------------------------------------------------------------
module pac_prefix_tbl #(
  parameter int unsigned ENTRIES   = pac_pkg::PrefixEntriesDef,
  parameter int unsigned RULE_BITS = pac_pkg::RuleBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  pac_pkg::pac_wr_t               wr_i,
  input  logic [1:0][31:0]               addr_i,
  output logic [1:0]                     hit_o,
  output logic [1:0][RULE_BITS-1:0]      rule_o
);
  import pac_pkg::*;

  localparam int unsigned Groups = (ENTRIES + GroupSize - 1) / GroupSize;

  logic [31:0]          net_q  [ENTRIES];
  logic [31:0]          mask_q [ENTRIES];
  logic [RULE_BITS-1:0] rule_q [ENTRIES];
  logic [ENTRIES-1:0]   valid_q;
  logic [RULE_BITS-1:0] wr_rule;

  logic [1:0][Groups-1:0]                grp_hit_d, grp_hit_q;
  logic [1:0][Groups-1:0][RULE_BITS-1:0] grp_rule_d, grp_rule_q;
  logic [1:0]                            hit_d;
  logic [1:0][RULE_BITS-1:0]             rule_d;

  assign wr_rule = RULE_BITS'(wr_i.rule);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (int'(wr_i.index) == i) begin
          if (wr_i.prefix_we) begin
            valid_q[i] <= 1'b1;
          end else if (wr_i.prefix_clr) begin
            valid_q[i] <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (wr_i.prefix_we && int'(wr_i.index) == i) begin
        net_q[i]  <= wr_i.network;
        mask_q[i] <= wr_i.mask;
        rule_q[i] <= wr_rule;
      end
    end
  end

  always_comb begin
    int unsigned idx;
    grp_hit_d  = '0;
    grp_rule_d = '0;
    for (int c = 0; c < 2; c++) begin
      for (int g = 0; g < Groups; g++) begin
        for (int k = GroupSize - 1; k >= 0; k--) begin
          idx = g * GroupSize + k;
          if (idx < ENTRIES) begin
            if (valid_q[idx] && addr_i[c] != '0 &&
                (addr_i[c] & mask_q[idx]) == net_q[idx]) begin
              grp_hit_d[c][g]  = 1'b1;
              grp_rule_d[c][g] = rule_q[idx];
            end
          end
        end
      end
    end
  end

  always_comb begin
    hit_d  = '0;
    rule_d = '0;
    for (int c = 0; c < 2; c++) begin
      for (int g = Groups - 1; g >= 0; g--) begin
        if (grp_hit_q[c][g]) begin
          hit_d[c]  = 1'b1;
          rule_d[c] = grp_rule_q[c][g];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      grp_hit_q  <= grp_hit_d;
      grp_rule_q <= grp_rule_d;
      hit_o      <= hit_d;
      rule_o     <= rule_d;
    end
  end

endmodule

// ----- sv/pac_port_tbl.sv -----
// ----------------------------------------------------------------------------
// pac_port_tbl
// Port table with parallel compare of two ports and a two-stage registered
// first-hit reduction.
// ----------------------------------------------------------------------------
module pac_port_tbl #(
  parameter int unsigned ENTRIES   = pac_pkg::PortEntriesDef,
  parameter int unsigned RULE_BITS = pac_pkg::RuleBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  pac_pkg::pac_wr_t               wr_i,
  input  logic [1:0][15:0]               port_i,
  input  logic [1:0]                     need_i,
  output logic [1:0]                     hit_o,
  output logic [1:0][RULE_BITS-1:0]      rule_o
);
  import pac_pkg::*;

  localparam int unsigned Groups = (ENTRIES + GroupSize - 1) / GroupSize;

  logic [15:0]          value_q [ENTRIES];
  logic [RULE_BITS-1:0] rule_q  [ENTRIES];
  logic [1:0]           flags_q [ENTRIES];
  logic [RULE_BITS-1:0] wr_rule;

  logic [1:0][Groups-1:0]                grp_hit_d, grp_hit_q;
  logic [1:0][Groups-1:0][RULE_BITS-1:0] grp_rule_d, grp_rule_q;
  logic [1:0]                            hit_d;
  logic [1:0][RULE_BITS-1:0]             rule_d;

  assign wr_rule = RULE_BITS'(wr_i.rule);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        flags_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (wr_i.port_we && int'(wr_i.index) == i) begin
          flags_q[i] <= wr_i.protocols;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (wr_i.port_we && int'(wr_i.index) == i) begin
        value_q[i] <= wr_i.port;
        rule_q[i]  <= wr_rule;
      end
    end
  end

  always_comb begin
    int unsigned idx;
    grp_hit_d  = '0;
    grp_rule_d = '0;
    for (int c = 0; c < 2; c++) begin
      for (int g = 0; g < Groups; g++) begin
        for (int k = GroupSize - 1; k >= 0; k--) begin
          idx = g * GroupSize + k;
          if (idx < ENTRIES) begin
            if (port_i[c] != '0 && value_q[idx] == port_i[c] &&
                (flags_q[idx] & need_i) != '0) begin
              grp_hit_d[c][g]  = 1'b1;
              grp_rule_d[c][g] = rule_q[idx];
            end
          end
        end
      end
    end
  end

  always_comb begin
    hit_d  = '0;
    rule_d = '0;
    for (int c = 0; c < 2; c++) begin
      for (int g = Groups - 1; g >= 0; g--) begin
        if (grp_hit_q[c][g]) begin
          hit_d[c]  = 1'b1;
          rule_d[c] = grp_rule_q[c][g];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      grp_hit_q  <= grp_hit_d;
      grp_rule_q <= grp_rule_d;
      hit_o      <= hit_d;
      rule_o     <= rule_d;
    end
  end

endmodule

// ----- sv/packet_acl_classifier_unit.sv -----
// Throughput: 1 transaction per cycle; the four stages stall together when
// the output register is full and the master side is not ready.
// Table writes take effect at the accepting edge and are seen by every later
// filter transaction. Reset clears prefix valid bits, port flags and all
// stage valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
// packet_acl_classifier_unit
// IPv4 prefix and TCP/UDP port ACL filter, four-stage pipeline.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module packet_acl_classifier_unit #(
  parameter int unsigned PREFIX_ENTRIES = pac_pkg::PrefixEntriesDef,
  parameter int unsigned PORT_ENTRIES   = pac_pkg::PortEntriesDef,
  parameter int unsigned RULE_BITS      = pac_pkg::RuleBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  // op
  input  logic [1:0]   s_tuser_i,
  // entry_index, src_ip, dst_ip, source port, destination port, protocol,
  // entry_network, entry_mask, entry_port, entry_protocols, entry_rule
  input  logic [199:0] s_tdata_i,
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  // verdict, layer, rule_id, zero pad
  output logic [15:0]  m_tdata_o
);
  import pac_pkg::*;

  logic    adv;
  logic    accept;
  pac_op_e in_op;
  pac_wr_t wr;

  logic        v1_q, v2_q, v3_q, v4_q;
  pac_op_e     op1_q, op2_q, op3_q;
  logic [31:0] src_ip1_q, dst_ip1_q;
  logic [15:0] sport1_q, dport1_q;
  logic [7:0]  proto1_q;
  logic [1:0]  need;

  logic [1:0]                pre_hit, port_hit;
  logic [1:0][RULE_BITS-1:0] pre_rule, port_rule;

  logic       verdict_d, verdict_q;
  logic       layer_d, layer_q;
  logic [7:0] rule_d, rule_q;

  assign adv        = !v4_q || m_tready_i;
  assign s_tready_o = adv;
  assign accept     = s_tvalid_i && adv;
  assign in_op      = pac_op_e'(s_tuser_i);

  always_comb begin
    wr            = '0;
    wr.index      = s_tdata_i[5:0];
    wr.network    = s_tdata_i[141:110];
    wr.mask       = s_tdata_i[173:142];
    wr.port       = s_tdata_i[189:174];
    wr.protocols  = s_tdata_i[191:190];
    wr.rule       = s_tdata_i[199:192];
    if (accept) begin
      unique case (in_op)
        OP_WRITE_PREFIX: wr.prefix_we  = 1'b1;
        OP_WRITE_PORT:   wr.port_we    = 1'b1;
        OP_CLEAR_PREFIX: wr.prefix_clr = 1'b1;
        OP_FILTER:       ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_tvalid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op1_q     <= in_op;
      src_ip1_q <= s_tdata_i[37:6];
      dst_ip1_q <= s_tdata_i[69:38];
      sport1_q  <= s_tdata_i[85:70];
      dport1_q  <= s_tdata_i[101:86];
      proto1_q  <= s_tdata_i[109:102];
      op2_q     <= op1_q;
      op3_q     <= op2_q;
      verdict_q <= verdict_d;
      layer_q   <= layer_d;
      rule_q    <= rule_d;
    end
  end

  assign need = {proto1_q == PROTO_UDP, proto1_q == PROTO_TCP};

  pac_prefix_tbl #(
    .ENTRIES   (PREFIX_ENTRIES),
    .RULE_BITS (RULE_BITS)
  ) u_prefix (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .wr_i   (wr),
    .addr_i ({dst_ip1_q, src_ip1_q}),
    .hit_o  (pre_hit),
    .rule_o (pre_rule)
  );

  pac_port_tbl #(
    .ENTRIES   (PORT_ENTRIES),
    .RULE_BITS (RULE_BITS)
  ) u_port (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .wr_i   (wr),
    .port_i ({sport1_q, dport1_q}),
    .need_i (need),
    .hit_o  (port_hit),
    .rule_o (port_rule)
  );

  always_comb begin
    verdict_d = 1'b0;
    layer_d   = 1'b0;
    rule_d    = '0;
    if (op3_q == OP_FILTER) begin
      if (pre_hit[0]) begin
        verdict_d = 1'b1;
        rule_d    = 8'(pre_rule[0]);
      end else if (pre_hit[1]) begin
        verdict_d = 1'b1;
        rule_d    = 8'(pre_rule[1]);
      end else if (port_hit[0]) begin
        verdict_d = 1'b1;
        layer_d   = 1'b1;
        rule_d    = 8'(port_rule[0]);
      end else if (port_hit[1]) begin
        verdict_d = 1'b1;
        layer_d   = 1'b1;
        rule_d    = 8'(port_rule[1]);
      end
    end
  end

  assign m_tvalid_o = v4_q;
  assign m_tdata_o  = {6'b0, rule_q, layer_q, verdict_q};

  `ASSERT_RST(a_reset_empty, !rst_ni |-> !m_tvalid_o)
  `ASSERT_CHK(a_stall_blocks_input, m_tvalid_o && !m_tready_i |-> !s_tready_o)
  `ASSERT_CHK(a_accept_clean, m_tvalid_o && !verdict_q |-> !layer_q && rule_q == 8'd0)
  `ASSERT_CHK(a_write_no_drop, v3_q && adv && op3_q != OP_FILTER |=> !verdict_q)

endmodule
